// ===== rtl/core/ptts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptts_pkg
// Shared types, codes and the microcode table of the tick scheduler.
// ----------------------------------------------------------------------------
package ptts_pkg;

  localparam int unsigned SLOTS_DEF = 16;
  localparam int unsigned TICK_W    = 10;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned SLOT_W    = 4;

  typedef enum logic [0:0] {
    OP_REGISTER = 1'b0,
    OP_TICK     = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_USED   = 2'd1,
    ST_BADIDX = 2'd2
  } status_e;

  typedef struct packed {
    op_e               op;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] period_ms;
    logic [TIME_W-1:0] first_delay_ms;
  } req_t;

  typedef struct packed {
    logic              fired;
    logic [SLOT_W-1:0] fired_slot;
    status_e           status;
    logic              last;
  } res_t;

  // Steps of the sequencer program.
  typedef enum logic [2:0] {
    S_IDLE  = 3'd0,
    S_REG   = 3'd1,
    S_TINIT = 3'd2,
    S_EXEC  = 3'd3,
    S_FIN   = 3'd4
  } step_e;

  typedef enum logic [1:0] {
    JMP_NEXT     = 2'd0,
    JMP_GOTO     = 2'd1,
    JMP_DISPATCH = 2'd2,
    JMP_LOOP     = 2'd3
  } jmp_e;

  typedef struct packed {
    logic  busy;
    logic  do_reg;
    logic  do_init;
    logic  do_exec;
    logic  do_fin;
    jmp_e  jmp;
    step_e target;
    step_e target_alt;
  } ctrl_t;

  // Strobes from the sequencer into the slot table.
  typedef struct packed {
    logic rd_en;
    logic per_we;
    logic rem_we;
    logic used_set;
  } tbl_ctrl_t;

  // Program: dispatch on the operation, one step for a registration, and for
  // a tick a prime read, one step per slot, then a flush of the held result.
  function automatic ctrl_t ucode(step_e s);
    ctrl_t c;
    c = '{busy: 1'b0, do_reg: 1'b0, do_init: 1'b0, do_exec: 1'b0, do_fin: 1'b0,
          jmp: JMP_NEXT, target: S_IDLE, target_alt: S_IDLE};
    case (s)
      S_IDLE: begin
        c.jmp        = JMP_DISPATCH;
        c.target     = S_REG;
        c.target_alt = S_TINIT;
      end
      S_REG: begin
        c.busy   = 1'b1;
        c.do_reg = 1'b1;
        c.jmp    = JMP_GOTO;
        c.target = S_IDLE;
      end
      S_TINIT: begin
        c.busy    = 1'b1;
        c.do_init = 1'b1;
        c.jmp     = JMP_NEXT;
      end
      S_EXEC: begin
        c.busy    = 1'b1;
        c.do_exec = 1'b1;
        c.jmp     = JMP_LOOP;
      end
      S_FIN: begin
        c.busy   = 1'b1;
        c.do_fin = 1'b1;
        c.jmp    = JMP_GOTO;
        c.target = S_IDLE;
      end
      default: begin
        c.jmp    = JMP_GOTO;
        c.target = S_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/periodic_task_tick_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler
// Time-triggered cooperative scheduler with a microcoded slot walker.
// ----------------------------------------------------------------------------
// Usage:
//   A word on req_i is taken at a rising edge with start high and busy low.
//   Results come on res_o for one cycle each, marked by res_valid_o; the
//   receiver cannot stall them, so no back-pressure exists on that side.
//   The user writes tick_ms on the cfg channel (cfg_ready_o is always high)
//   only while idle, as the block does not enforce it; it resets to 1.
//   A registration holds busy in the S_REG step; its result strobes in the
//   cycle after, when the next word may already be taken. A tick holds
//   busy through a prime read, one step per slot and a flush, and the next
//   word is taken only after busy falls. A fired slot is held until the
//   next firing slot is found or the walk ends, since last is known only
//   then; the final result strobes right after busy falls.
//   Reset clears the used flags and the sequencer; period and delay memories
//   are not cleared, and their words matter only for used slots.
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler #(
  parameter int unsigned SLOTS = ptts_pkg::SLOTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  ptts_pkg::req_t                req_i,
  output logic                          res_valid_o,
  output ptts_pkg::res_t                res_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ptts_pkg::TICK_W-1:0]   cfg_data_i
);
  import ptts_pkg::*;

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  step_e              step_q, step_d;
  ctrl_t              ctrl;
  logic               accept;
  req_t               in_q;
  logic [TICK_W-1:0]  tick_q;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               pend_q, pend_d;
  logic [SLOT_W-1:0]  pend_slot_q, pend_slot_d;
  logic               res_valid_q, res_valid_d;
  res_t               res_q, res_d;

  tbl_ctrl_t          tbl;
  logic [IDX_W-1:0]   wr_addr, rd_addr;
  logic [TIME_W-1:0]  rem_wdata;
  logic [SLOTS-1:0]   used;
  logic [TIME_W-1:0]  per_rd, rem_rd;

  logic               idx_last;
  logic [IDX_W-1:0]   idx_inc;
  logic [IDX_W+3:0]   slot_ext;
  logic [IDX_W-1:0]   slot_addr;
  logic               slot_bad;
  logic [IDX_W+3:0]   idx_ext;
  logic [SLOT_W-1:0]  idx_slot;
  logic               cur_used;
  logic               fire;
  logic [TIME_W-1:0]  base;
  logic [TIME_W-1:0]  rem_next;

  assign ctrl        = ucode(step_q);
  assign busy        = ctrl.busy;
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  // Index helpers; the padding keeps the selects valid at any slot count.
  assign idx_last  = (idx_q == IDX_W'(SLOTS - 1));
  assign idx_inc   = idx_q + IDX_W'(1);
  assign slot_ext  = {{IDX_W{1'b0}}, in_q.slot};
  assign slot_addr = slot_ext[IDX_W-1:0];
  assign slot_bad  = ({{(32-SLOT_W){1'b0}}, in_q.slot} >= 32'(SLOTS));
  assign idx_ext   = {4'b0000, idx_q};
  assign idx_slot  = idx_ext[SLOT_W-1:0];

  // A slot at zero fires and is reloaded; the reload plus zero is the period.
  assign cur_used = used[idx_q];
  assign fire     = ctrl.do_exec && cur_used && (rem_rd == '0);
  assign base     = (rem_rd == '0) ? per_rd : rem_rd;
  assign rem_next = base - {{(TIME_W-TICK_W){1'b0}}, tick_q};

  // Next step.
  always_comb begin
    step_d = step_q;
    case (ctrl.jmp)
      JMP_NEXT:     step_d = step_e'(step_q + 3'd1);
      JMP_GOTO:     step_d = ctrl.target;
      JMP_DISPATCH: begin
        if (accept) begin
          step_d = (req_i.op == OP_TICK) ? ctrl.target_alt : ctrl.target;
        end
      end
      JMP_LOOP: begin
        if (idx_last) begin
          step_d = step_e'(step_q + 3'd1);
        end
      end
      default:      step_d = S_IDLE;
    endcase
  end

  // Datapath controls and results.
  always_comb begin
    tbl         = '{rd_en: 1'b0, per_we: 1'b0, rem_we: 1'b0, used_set: 1'b0};
    wr_addr     = slot_addr;
    rd_addr     = '0;
    rem_wdata   = in_q.first_delay_ms;
    idx_d       = idx_q;
    pend_d      = pend_q;
    pend_slot_d = pend_slot_q;
    res_valid_d = 1'b0;
    res_d       = '{fired: 1'b0, fired_slot: '0, status: ST_OK, last: 1'b1};

    if (ctrl.do_reg) begin
      res_valid_d = 1'b1;
      if (slot_bad) begin
        res_d.status = ST_BADIDX;
      end else if (used[slot_addr]) begin
        res_d.status = ST_USED;
      end else begin
        tbl.per_we   = 1'b1;
        tbl.rem_we   = 1'b1;
        tbl.used_set = 1'b1;
      end
    end

    if (ctrl.do_init) begin
      tbl.rd_en = 1'b1;
      idx_d     = '0;
      pend_d    = 1'b0;
    end

    if (ctrl.do_exec) begin
      // Read one slot ahead while the current one is written back.
      tbl.rd_en  = 1'b1;
      rd_addr    = idx_last ? '0 : idx_inc;
      idx_d      = idx_last ? idx_q : idx_inc;
      wr_addr    = idx_q;
      rem_wdata  = rem_next;
      tbl.rem_we = cur_used;
      if (fire) begin
        if (pend_q) begin
          res_valid_d = 1'b1;
          res_d       = '{fired: 1'b1, fired_slot: pend_slot_q, status: ST_OK,
                          last: 1'b0};
        end
        pend_d      = 1'b1;
        pend_slot_d = idx_slot;
      end
    end

    if (ctrl.do_fin) begin
      res_valid_d = 1'b1;
      if (pend_q) begin
        res_d = '{fired: 1'b1, fired_slot: pend_slot_q, status: ST_OK, last: 1'b1};
      end
      pend_d = 1'b0;
    end
  end

  ptts_slot_table #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W)
  ) u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (tbl),
    .wr_addr_i   (wr_addr),
    .rd_addr_i   (rd_addr),
    .per_wdata_i (in_q.period_ms),
    .rem_wdata_i (rem_wdata),
    .used_o      (used),
    .per_rdata_o (per_rd),
    .rem_rdata_o (rem_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= S_IDLE;
      tick_q      <= TICK_W'(1);
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      pend_q      <= pend_d;
      res_valid_q <= res_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        tick_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    pend_slot_q <= pend_slot_d;
    res_q       <= res_d;
    if (accept) begin
      in_q <= req_i;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // Every result word comes from a step taken while busy.
  a_res_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(busy))
    else $error("result strobe without a preceding busy step");

  // No fired slot may be left held once the walk is over.
  a_no_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> !pend_q)
    else $error("held fired result left over at idle");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.fired) |-> res_o.last)
    else $error("non-fired result not marked last");

  a_fired_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.fired) |-> (res_o.status == ST_OK))
    else $error("fired result with non-ok status");

endmodule

// ===== rtl/core/ptts_slot_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptts_slot_table
// Slot storage: used flags in flops, period and remaining delay in memories
// with one write and one registered read port each.
// ----------------------------------------------------------------------------
module ptts_slot_table #(
  parameter int unsigned SLOTS = 16,
  parameter int unsigned IDX_W = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ptts_pkg::tbl_ctrl_t            ctrl_i,
  input  logic [IDX_W-1:0]               wr_addr_i,
  input  logic [IDX_W-1:0]               rd_addr_i,
  input  logic [ptts_pkg::TIME_W-1:0]    per_wdata_i,
  input  logic [ptts_pkg::TIME_W-1:0]    rem_wdata_i,
  output logic [SLOTS-1:0]               used_o,
  output logic [ptts_pkg::TIME_W-1:0]    per_rdata_o,
  output logic [ptts_pkg::TIME_W-1:0]    rem_rdata_o
);
  import ptts_pkg::*;

  logic [SLOTS-1:0]  used_q;
  logic [TIME_W-1:0] per_mem [SLOTS];
  logic [TIME_W-1:0] rem_mem [SLOTS];
  logic [TIME_W-1:0] per_rd_q;
  logic [TIME_W-1:0] rem_rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (ctrl_i.used_set) begin
      used_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.per_we) begin
      per_mem[wr_addr_i] <= per_wdata_i;
    end
    if (ctrl_i.rd_en) begin
      per_rd_q <= per_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rem_we) begin
      rem_mem[wr_addr_i] <= rem_wdata_i;
    end
    if (ctrl_i.rd_en) begin
      rem_rd_q <= rem_mem[rd_addr_i];
    end
  end

  assign used_o      = used_q;
  assign per_rdata_o = per_rd_q;
  assign rem_rdata_o = rem_rd_q;

endmodule

// ===== tb/ptts_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptts_checker
// Watches the request, result and tick-length channels of the tick scheduler.
// It keeps its own slot table and compares every result word, field by field,
// with the oldest predicted word.
// ----------------------------------------------------------------------------
module ptts_checker #(
  parameter int unsigned SLOTS = ptts_pkg::SLOTS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        busy_i,
  input  ptts_pkg::req_t              req_i,
  input  logic                        res_valid_i,
  input  ptts_pkg::res_t              res_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [ptts_pkg::TICK_W-1:0] cfg_data_i,
  output int                          err_count_o,
  output int                          pending_o,
  output int                          result_count_o,
  output int                          fire_count_o
);
  import ptts_pkg::*;

  localparam int MAX_WORDS = 16;

  logic              slot_armed     [SLOTS];
  logic [TIME_W-1:0] slot_reload    [SLOTS];
  logic [TIME_W-1:0] slot_countdown [SLOTS];
  logic [TICK_W-1:0] tick_len;
  res_t              due_words [$];
  int                errors   = 0;
  int                words    = 0;
  int                firings  = 0;

  // One request word: a registration answers with its status, a tick walks
  // the armed slots in priority order.
  task automatic run_scheduler_step(input req_t r);
    res_t    held;
    bit      have_held;
    status_e st;
    int      n;
    int      i;
    have_held = 1'b0;
    n = 0;
    if (r.op == OP_REGISTER) begin
      if (int'(r.slot) >= SLOTS) begin
        st = ST_BADIDX;
      end else if (slot_armed[r.slot]) begin
        st = ST_USED;
      end else begin
        slot_armed[r.slot]     = 1'b1;
        slot_reload[r.slot]    = r.period_ms;
        slot_countdown[r.slot] = r.first_delay_ms;
        st = ST_OK;
      end
      due_words.push_back('{fired: 1'b0, fired_slot: '0, status: st, last: 1'b1});
    end else begin
      for (i = 0; i < SLOTS; i++) begin
        if (slot_armed[i]) begin
          if (slot_countdown[i] == '0) begin
            if (n < MAX_WORDS) begin
              // The previous firing is known not to be the last one now.
              if (have_held) due_words.push_back(held);
              held = '{fired: 1'b1, fired_slot: SLOT_W'(i), status: ST_OK, last: 1'b0};
              have_held = 1'b1;
              n++;
            end
            slot_countdown[i] = slot_countdown[i] + slot_reload[i];
          end
          slot_countdown[i] = slot_countdown[i] - TIME_W'(tick_len);
        end
      end
      if (have_held) begin
        held.last = 1'b1;
        due_words.push_back(held);
      end else begin
        due_words.push_back('{fired: 1'b0, fired_slot: '0, status: ST_OK, last: 1'b1});
      end
    end
  endtask

  task automatic check_word(input res_t got);
    res_t want;
    if (due_words.size() == 0) begin
      $error("unexpected result word: fired %0d, fired_slot %0d, status %0d, last %0d",
             got.fired, got.fired_slot, got.status, got.last);
      errors++;
    end else begin
      want = due_words.pop_front();
      if (got.fired !== want.fired) begin
        $error("fired: expected %0d, actual %0d", want.fired, got.fired);
        errors++;
      end
      if (got.fired_slot !== want.fired_slot) begin
        $error("fired_slot: expected %0d, actual %0d", want.fired_slot, got.fired_slot);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, got.last);
        errors++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_armed[i]     = 1'b0;
        slot_reload[i]    = '0;
        slot_countdown[i] = '0;
      end
      tick_len = TICK_W'(1);
      due_words.delete();
      pending_o <= 0;
    end else begin
      if (res_valid_i) begin
        check_word(res_i);
        words++;
        if (res_i.fired === 1'b1) firings++;
      end
      if (cfg_valid_i && cfg_ready_i) tick_len = cfg_data_i;
      if (start_i && !busy_i) run_scheduler_step(req_i);
      err_count_o    <= errors;
      pending_o      <= due_words.size();
      result_count_o <= words;
      fire_count_o   <= firings;
    end
  end

endmodule

// ===== tb/periodic_task_tick_scheduler_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler_tb
// Drives registrations and ticks into the scheduler under a series of tick
// lengths, with random gaps between request words, and lets the checker
// compare every result word against its own model of the slot table.
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler_tb;
  import ptts_pkg::*;

  localparam int unsigned SLOTS = SLOTS_DEF;
  localparam int IDLE_LIMIT  = 1000;
  localparam int TAIL_CYCLES = SLOTS + 8;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              start     = 1'b0;
  logic              busy;
  req_t              req       = '0;
  logic              res_valid;
  res_t              res;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [TICK_W-1:0] cfg_data  = '0;

  int err_count;
  int pending;
  int result_count;
  int fire_count;

  logic [TICK_W-1:0] tick_now = TICK_W'(1);
  bit                slot_taken [SLOTS];
  bit                steady = 1'b0;
  int                n_ticks = 0;
  int                n_regs = 0;
  int                n_settings = 1;
  int                idle_cycles;

  always #1 clk = ~clk;

  periodic_task_tick_scheduler dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start       (start),
    .busy        (busy),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_o       (res),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  ptts_checker #(.SLOTS(SLOTS)) i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_i         (busy),
    .req_i          (req),
    .res_valid_i    (res_valid),
    .res_i          (res),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .err_count_o    (err_count),
    .pending_o      (pending),
    .result_count_o (result_count),
    .fire_count_o   (fire_count)
  );

  function automatic req_t reg_word(input logic [SLOT_W-1:0] slot,
                                    input logic [TIME_W-1:0] period,
                                    input logic [TIME_W-1:0] delay);
    return '{op: OP_REGISTER, slot: slot, period_ms: period, first_delay_ms: delay};
  endfunction

  // The slot and time fields are ignored on a tick, so they carry noise.
  function automatic req_t tick_word();
    return '{op: OP_TICK, slot: SLOT_W'($urandom), period_ms: $urandom,
             first_delay_ms: $urandom};
  endfunction

  // Period and first delay are small multiples of the current tick length,
  // so that the task actually fires instead of wrapping around.
  function automatic req_t tuned_reg(input bit want_free);
    logic [SLOT_W-1:0] free_list [$];
    logic [SLOT_W-1:0] pick;
    int                i;
    for (i = 0; i < SLOTS; i++) begin
      if (!slot_taken[i]) free_list.push_back(SLOT_W'(i));
    end
    if (want_free && free_list.size() > 0) begin
      pick = free_list[$urandom_range(0, free_list.size() - 1)];
    end else begin
      pick = SLOT_W'($urandom_range(0, SLOTS - 1));
    end
    return reg_word(pick, $urandom_range(0, 4) * tick_now, $urandom_range(0, 3) * tick_now);
  endfunction

  task automatic issue(input req_t word);
    int gap;
    int roll;
    roll = $urandom_range(0, 99);
    if (steady) begin
      gap = 0;
    end else if (roll < 60) begin
      gap = $urandom_range(0, 2);
    end else if (roll < 92) begin
      gap = $urandom_range(3, 20);
    end else begin
      gap = $urandom_range(30, 80);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req   <= word;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (word.op == OP_TICK) begin
      n_ticks++;
    end else begin
      n_regs++;
      if (int'(word.slot) < SLOTS) slot_taken[word.slot] = 1'b1;
    end
  endtask

  // Every request word answers with at least one result word, so the block
  // is idle once nothing is awaited and busy is low.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
  endtask

  task automatic set_tick(input logic [TICK_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    tick_now = value;
    n_settings++;
  endtask

  task automatic random_phase(input logic [TICK_W-1:0] value, input int count);
    int roll;
    set_tick(value);
    steady = ($urandom_range(0, 3) == 0);
    repeat (2) issue(tuned_reg(1'b1));
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 65) begin
        issue(tick_word());
      end else if (roll < 82) begin
        issue(tuned_reg(1'b0));
      end else begin
        issue(reg_word(SLOT_W'($urandom), $urandom, $urandom));
      end
    end
  endtask

  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || res_valid || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("periodic_task_tick_scheduler test failed");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Tick length is still at its reset value of one here.
    issue(tick_word());
    issue(reg_word(SLOT_W'(0), TIME_W'(2), TIME_W'(0)));
    issue(reg_word(SLOT_W'(0), TIME_W'(5), TIME_W'(5)));
    issue(reg_word(SLOT_W'(15), '1, '1));
    issue(reg_word(SLOT_W'(5), TIME_W'(0), TIME_W'(1)));
    issue(reg_word(SLOT_W'(7), TIME_W'(1), TIME_W'(0)));
    repeat (4) issue(tick_word());

    // Above the nominal range; the delay of slot 9 steps over zero and wraps.
    set_tick(TICK_W'(1023));
    issue(reg_word(SLOT_W'(3), TIME_W'(1023), TIME_W'(0)));
    issue(reg_word(SLOT_W'(9), TIME_W'(2046), TIME_W'(3)));
    repeat (3) issue(tick_word());

    // With a zero tick length a zero-period task fires on every tick.
    set_tick('0);
    issue(reg_word(SLOT_W'(10), TIME_W'(0), TIME_W'(0)));
    issue(reg_word(SLOT_W'(10), TIME_W'(7), TIME_W'(7)));
    repeat (3) issue(tick_word());

    random_phase(TICK_W'(1000), 12);
    random_phase(TICK_W'($urandom_range(2, 999)), 12);
    random_phase(TICK_W'(1), 12);
    random_phase(TICK_W'(2), 12);
    random_phase(TICK_W'(1023), 12);
    random_phase(TICK_W'($urandom_range(1, 1000)), 12);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d ticks and %0d registrations under %0d tick lengths, from 0 to 1023.",
             n_ticks, n_regs, n_settings);
    $display("Compared %0d result words, %0d of them slot firings.", result_count, fire_count);
    if (err_count == 0 && pending == 0) begin
      $display("periodic_task_tick_scheduler test passed");
    end else begin
      $display("periodic_task_tick_scheduler test failed");
    end
    $finish;
  end

endmodule
